// ----- sv/lqs_pkg.sv -----
// Package with the transaction types and codes for the linear queue with search.
package lqs_pkg;

  // Operation codes carried by an input transaction.
  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_DELETE  = 2'd1;
  localparam logic [1:0] OP_SEARCH  = 2'd2;
  localparam logic [1:0] OP_DISPLAY = 2'd3;

  // Status codes carried by a result transaction.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // Field widths fixed by the interface.
  localparam int DATA_W = 32;
  localparam int POS_W  = 4;

  typedef struct packed {
    logic [1:0]               operation;
    logic signed [DATA_W-1:0] data_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] entry_value;
    logic [POS_W-1:0]         position;
    logic                     last_of_run;
  } out_item_t;

  // Builds one result transaction.
  function automatic out_item_t make_result(logic [1:0] status,
                                            logic signed [DATA_W-1:0] value,
                                            logic [POS_W-1:0] position,
                                            logic last);
    out_item_t r;
    r.status      = status;
    r.entry_value = value;
    r.position    = position;
    r.last_of_run = last;
    return r;
  endfunction

endpackage

// ----- sv/linear_queue_with_search_unit.sv -----
// Linear array queue of signed words with insert, delete, search and display.
// A search reads the entries one at a time from the front, and a display gives one result per entry.
// A new transaction is accepted only after the last result of the previous one enters the output register.
// Reset (synchronous, active low) empties the queue at once; the slot memory is not cleared.
module linear_queue_with_search_unit #(
  parameter int DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lqs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lqs_pkg::out_item_t out_data
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);

  // Control states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]                       state_r, state_nxt;
  logic [IDX_W-1:0]                 front_r, front_nxt;
  logic [IDX_W-1:0]                 rear_r, rear_nxt;
  logic                             empty_r, empty_nxt;
  logic [IDX_W-1:0]                 ptr_r, ptr_nxt;
  logic [1:0]                       op_r, op_nxt;
  logic signed [lqs_pkg::DATA_W-1:0] val_r, val_nxt;
  lqs_pkg::out_item_t               res_r, res_nxt;
  lqs_pkg::out_item_t               out_data_r, out_data_nxt;
  logic                             out_valid_r, out_valid_nxt;

  // Slot memory with one write and one registered read port.
  logic signed [lqs_pkg::DATA_W-1:0] slot_mem [DEPTH];
  logic signed [lqs_pkg::DATA_W-1:0] rd_data_r;
  logic                             mem_we;
  logic [IDX_W-1:0]                 mem_waddr;
  logic                             mem_re;
  logic [IDX_W-1:0]                 mem_raddr;
  logic [IDX_W-1:0]                 ptr_inc;
  logic [lqs_pkg::POS_W-1:0]        found_pos;
  logic                             in_accept;

  assign in_ready  = (state_r == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign ptr_inc   = ptr_r + 1'b1;

  // Position from the front, counted from one and wrapped to the field width.
  assign found_pos = lqs_pkg::POS_W'({1'b0, ptr_r} - {1'b0, front_r} + 1'b1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= val_nxt;
    end
    if (mem_re) begin
      rd_data_r <= slot_mem[mem_raddr];
    end
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    rear_nxt      = rear_r;
    empty_nxt     = empty_r;
    ptr_nxt       = ptr_r;
    op_nxt        = op_r;
    val_nxt       = val_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mem_we        = 1'b0;
    mem_waddr     = rear_r;
    mem_re        = 1'b0;
    mem_raddr     = ptr_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          op_nxt  = in_data.operation;
          val_nxt = in_data.data_value;
          unique case (in_data.operation)
            lqs_pkg::OP_INSERT: begin
              state_nxt = S_EMIT;
              if (empty_r) begin
                front_nxt = '0;
                rear_nxt  = '0;
                empty_nxt = 1'b0;
                mem_we    = 1'b1;
                mem_waddr = '0;
                res_nxt   = lqs_pkg::make_result(lqs_pkg::ST_OK, '0, '0, 1'b1);
              end else if (rear_r == LAST_SLOT) begin
                res_nxt = lqs_pkg::make_result(lqs_pkg::ST_FULL, '0, '0, 1'b1);
              end else begin
                rear_nxt  = rear_r + 1'b1;
                mem_we    = 1'b1;
                mem_waddr = rear_r + 1'b1;
                res_nxt   = lqs_pkg::make_result(lqs_pkg::ST_OK, '0, '0, 1'b1);
              end
            end
            lqs_pkg::OP_DELETE: begin
              if (empty_r) begin
                res_nxt   = lqs_pkg::make_result(lqs_pkg::ST_EMPTY, '0, '0, 1'b1);
                state_nxt = S_EMIT;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = front_r;
                state_nxt = S_READ;
              end
            end
            lqs_pkg::OP_SEARCH: begin
              if (empty_r) begin
                res_nxt   = lqs_pkg::make_result(lqs_pkg::ST_NOT_FOUND, '0, '0, 1'b1);
                state_nxt = S_EMIT;
              end else begin
                ptr_nxt   = front_r;
                mem_re    = 1'b1;
                mem_raddr = front_r;
                state_nxt = S_READ;
              end
            end
            lqs_pkg::OP_DISPLAY: begin
              if (empty_r) begin
                res_nxt   = lqs_pkg::make_result(lqs_pkg::ST_EMPTY, '0, '0, 1'b1);
                state_nxt = S_EMIT;
              end else begin
                ptr_nxt   = front_r;
                mem_re    = 1'b1;
                mem_raddr = front_r;
                state_nxt = S_READ;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      // Slot data is on the read register; act on it.
      S_READ: begin
        unique case (op_r)
          lqs_pkg::OP_DELETE: begin
            res_nxt   = lqs_pkg::make_result(lqs_pkg::ST_OK, rd_data_r, '0, 1'b1);
            state_nxt = S_EMIT;
            if (front_r == rear_r) begin
              front_nxt = '0;
              rear_nxt  = '0;
              empty_nxt = 1'b1;
            end else begin
              front_nxt = front_r + 1'b1;
            end
          end
          lqs_pkg::OP_SEARCH: begin
            if (rd_data_r == val_r) begin
              res_nxt   = lqs_pkg::make_result(lqs_pkg::ST_OK, rd_data_r, found_pos, 1'b1);
              state_nxt = S_EMIT;
            end else if (ptr_r == rear_r) begin
              res_nxt   = lqs_pkg::make_result(lqs_pkg::ST_NOT_FOUND, '0, '0, 1'b1);
              state_nxt = S_EMIT;
            end else begin
              ptr_nxt   = ptr_inc;
              mem_re    = 1'b1;
              mem_raddr = ptr_inc;
            end
          end
          default: begin
            res_nxt   = lqs_pkg::make_result(lqs_pkg::ST_OK, rd_data_r, '0,
                                             ptr_r == rear_r);
            state_nxt = S_EMIT;
          end
        endcase
      end

      // Move the pending result into the output register when it is free.
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          if (res_r.last_of_run) begin
            state_nxt = S_IDLE;
          end else begin
            ptr_nxt   = ptr_inc;
            mem_re    = 1'b1;
            mem_raddr = ptr_inc;
            state_nxt = S_READ;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      rear_r      <= '0;
      empty_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      rear_r      <= rear_nxt;
      empty_r     <= empty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    op_r       <= op_nxt;
    val_r      <= val_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ----- tb/lqs_queue_checker.sv -----
// Checker that predicts and compares every result transaction of the linear queue.
`timescale 1ns / 100ps

module lqs_queue_checker #(
  parameter int DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  lqs_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  lqs_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 pending_count
);

  // Shadow copy of the queue contents and its indices.
  logic signed [lqs_pkg::DATA_W-1:0] slot_mem [DEPTH];
  int                                front_idx;
  int                                rear_idx;
  bit                                queue_empty;

  // Results still owed by the block, oldest first.
  lqs_pkg::out_item_t expected_results [$];

  // Queues one expected result; the position wraps to its port width.
  function automatic void push_result(logic [1:0] st,
                                      logic signed [lqs_pkg::DATA_W-1:0] val,
                                      int pos, logic last);
    lqs_pkg::out_item_t r;
    r.status      = st;
    r.entry_value = val;
    r.position    = pos[lqs_pkg::POS_W-1:0];
    r.last_of_run = last;
    expected_results.push_back(r);
  endfunction

  // Applies one accepted operation to the shadow queue and queues its results.
  function automatic void predict_queue_op(lqs_pkg::in_item_t item);
    bit hit;
    hit = 1'b0;
    case (item.operation)
      lqs_pkg::OP_INSERT: begin
        if (queue_empty) begin
          front_idx   = 0;
          rear_idx    = 0;
          slot_mem[0] = item.data_value;
          queue_empty = 1'b0;
          push_result(lqs_pkg::ST_OK, '0, 0, 1'b1);
        end else if (rear_idx >= DEPTH - 1) begin
          // The queue is linear: the rear slot stays taken until a full drain.
          push_result(lqs_pkg::ST_FULL, '0, 0, 1'b1);
        end else begin
          rear_idx++;
          slot_mem[rear_idx] = item.data_value;
          push_result(lqs_pkg::ST_OK, '0, 0, 1'b1);
        end
      end
      lqs_pkg::OP_DELETE: begin
        if (queue_empty) begin
          push_result(lqs_pkg::ST_EMPTY, '0, 0, 1'b1);
        end else begin
          push_result(lqs_pkg::ST_OK, slot_mem[front_idx], 0, 1'b1);
          if (front_idx == rear_idx) begin
            front_idx   = 0;
            rear_idx    = 0;
            queue_empty = 1'b1;
          end else begin
            front_idx++;
          end
        end
      end
      lqs_pkg::OP_SEARCH: begin
        // The first match from the front wins.
        if (!queue_empty) begin
          for (int i = front_idx; i <= rear_idx; i++) begin
            if (!hit && slot_mem[i] == item.data_value) begin
              push_result(lqs_pkg::ST_OK, slot_mem[i], i - front_idx + 1, 1'b1);
              hit = 1'b1;
            end
          end
        end
        if (!hit) begin
          push_result(lqs_pkg::ST_NOT_FOUND, '0, 0, 1'b1);
        end
      end
      lqs_pkg::OP_DISPLAY: begin
        if (queue_empty) begin
          push_result(lqs_pkg::ST_EMPTY, '0, 0, 1'b1);
        end else begin
          for (int i = front_idx; i <= rear_idx; i++) begin
            push_result(lqs_pkg::ST_OK, slot_mem[i], 0, i == rear_idx);
          end
        end
      end
    endcase
  endfunction

  // Compare results first, then predict, so a fresh prediction never masks a stray result.
  always @(posedge clk) begin
    lqs_pkg::out_item_t want;
    if (!rst_n) begin
      front_idx   = 0;
      rear_idx    = 0;
      queue_empty = 1'b1;
      expected_results.delete();
      fail_count    <= 0;
      pending_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          fail_count <= fail_count + 1;
          $display({"%0t: unexpected result: expected none, ",
                    "actual status=%0d value=%0d pos=%0d last=%0b"},
                   $time, out_data.status, out_data.entry_value, out_data.position,
                   out_data.last_of_run);
        end else begin
          want = expected_results.pop_front();
          if (out_data !== want) begin
            fail_count <= fail_count + 1;
            $display({"%0t: result mismatch: ",
                      "expected status=%0d value=%0d pos=%0d last=%0b, ",
                      "actual status=%0d value=%0d pos=%0d last=%0b"},
                     $time, want.status, want.entry_value, want.position,
                     want.last_of_run, out_data.status, out_data.entry_value,
                     out_data.position, out_data.last_of_run);
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_queue_op(in_data);
      end
      pending_count <= expected_results.size();
    end
  end

endmodule

// ----- tb/linear_queue_with_search_unit_test.sv -----
// Top of the queue testbench: clock, reset, stimulus, flow control and the verdict.
`timescale 1ns / 100ps

module linear_queue_with_search_unit_test;

  localparam int QDEPTH   = 8;
  localparam int N_RANDOM = 420;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  lqs_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  lqs_pkg::out_item_t out_data;
  int                 fail_count;
  int                 pending_count;

  // When set, neither side inserts gaps.
  bit        calm_phase;

  // Recently inserted values, so that searches often hit.
  logic signed [lqs_pkg::DATA_W-1:0] recent_vals [16];
  int                                recent_wr;

  linear_queue_with_search_unit #(.DEPTH(QDEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  lqs_queue_checker #(.DEPTH(QDEPTH)) queue_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // Clock with a 2 ns period.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (calm_phase) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Value mix: small repeating values, the extremes, or anything at all.
  function automatic logic signed [lqs_pkg::DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      return $urandom_range(0, 7);
    end else if (r == 4) begin
      case ($urandom_range(0, 3))
        0:       return {1'b1, {(lqs_pkg::DATA_W-1){1'b0}}};
        1:       return {1'b0, {(lqs_pkg::DATA_W-1){1'b1}}};
        2:       return '0;
        default: return '1;
      endcase
    end
    return $urandom;
  endfunction

  // Presents one transaction and waits until it is taken.
  task automatic send_item(logic [1:0] op, logic signed [lqs_pkg::DATA_W-1:0] val);
    lqs_pkg::in_item_t item;
    int                gap;
    item.operation  = op;
    item.data_value = val;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    if (op == lqs_pkg::OP_INSERT) begin
      recent_vals[recent_wr] = val;
      recent_wr = (recent_wr + 1) % 16;
    end
  endtask

  // Result side: bursts of ready separated by random stalls.
  initial begin
    int n;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      n = $urandom_range(1, 12);
      out_ready <= 1'b1;
      repeat (n) @(posedge clk);
      n = pick_gap();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    bit                                fill_phase;
    int                                r;
    logic [1:0]                        op;
    logic signed [lqs_pkg::DATA_W-1:0] val;

    calm_phase = 1'b0;
    recent_wr  = 0;
    for (int i = 0; i < 16; i++) recent_vals[i] = '0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Operations on an empty queue.
    send_item(lqs_pkg::OP_DELETE, $urandom);
    send_item(lqs_pkg::OP_SEARCH, '0);
    send_item(lqs_pkg::OP_DISPLAY, $urandom);

    // Fill every slot with extremes and a duplicate, then overflow.
    send_item(lqs_pkg::OP_INSERT, {1'b1, {(lqs_pkg::DATA_W-1){1'b0}}});
    send_item(lqs_pkg::OP_INSERT, {1'b0, {(lqs_pkg::DATA_W-1){1'b1}}});
    send_item(lqs_pkg::OP_INSERT, '0);
    send_item(lqs_pkg::OP_INSERT, '1);
    send_item(lqs_pkg::OP_INSERT, 32'sd5);
    send_item(lqs_pkg::OP_INSERT, 32'sd5);
    send_item(lqs_pkg::OP_INSERT, 32'h5555_5555);
    send_item(lqs_pkg::OP_INSERT, 32'haaaa_aaaa);
    send_item(lqs_pkg::OP_INSERT, 32'sd77);
    send_item(lqs_pkg::OP_DISPLAY, $urandom);

    // Hits at the front, at the rear, on a duplicate, and a miss.
    send_item(lqs_pkg::OP_SEARCH, {1'b1, {(lqs_pkg::DATA_W-1){1'b0}}});
    send_item(lqs_pkg::OP_SEARCH, 32'haaaa_aaaa);
    send_item(lqs_pkg::OP_SEARCH, 32'sd5);
    send_item(lqs_pkg::OP_SEARCH, 32'sd12345);

    // Space freed at the front is not reused until the queue drains.
    send_item(lqs_pkg::OP_DELETE, $urandom);
    send_item(lqs_pkg::OP_DELETE, $urandom);
    send_item(lqs_pkg::OP_INSERT, 32'sd99);
    send_item(lqs_pkg::OP_SEARCH, '1);
    send_item(lqs_pkg::OP_DISPLAY, $urandom);

    // Drain completely, underflow once, then insert into slot 0 again.
    repeat (6) send_item(lqs_pkg::OP_DELETE, $urandom);
    send_item(lqs_pkg::OP_DELETE, $urandom);
    send_item(lqs_pkg::OP_INSERT, 32'sh0123_4567);

    // Random traffic in alternating fill and drain phases.
    fill_phase = 1'b1;
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k % 24 == 0) begin
        fill_phase = ($urandom_range(0, 1) == 1);
        calm_phase = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < 10) begin
        op = lqs_pkg::OP_DISPLAY;
      end else if (r < 35) begin
        op = lqs_pkg::OP_SEARCH;
      end else if (fill_phase) begin
        op = (r < 85) ? lqs_pkg::OP_INSERT : lqs_pkg::OP_DELETE;
      end else begin
        op = (r < 85) ? lqs_pkg::OP_DELETE : lqs_pkg::OP_INSERT;
      end
      if (op == lqs_pkg::OP_SEARCH && $urandom_range(0, 9) < 6) begin
        val = recent_vals[$urandom_range(0, 15)];
      end else begin
        val = pick_value();
      end
      send_item(op, val);
    end
    in_valid <= 1'b0;
    calm_phase = 1'b0;

    // Let the last prediction land, wait for every owed result, then drain the pipe.
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
